// ===== sv/calculator_key_sequencer_defines.svh =====
// assertion macros shared by the sequencer checks
`ifndef CALCULATOR_KEY_SEQUENCER_DEFINES_SVH
`define CALCULATOR_KEY_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define CKS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calculator_key_sequencer: same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define CKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calculator_key_sequencer: next-cycle check failed");

`endif

// ===== sv/cks_pkg.sv =====
`timescale 1ns / 1ps
package cks_pkg;

  // key codes as they arrive on the input request
  typedef enum logic [2:0] {
    KEY_DIGIT  = 3'd0,
    KEY_PLUS   = 3'd1,
    KEY_MINUS  = 3'd2,
    KEY_MUL    = 3'd3,
    KEY_DIV    = 3'd4,
    KEY_EQUALS = 3'd5,
    KEY_CLEAR  = 3'd6
  } key_t;

  // no operator pending shares the digit code
  localparam key_t PEND_NONE = KEY_DIGIT;

  // step counter width of the control program
  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] upc_t;

  // datapath actions of one control word
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_AEQ_DROP,
    ACT_ACC_MAC,
    ACT_ACC_LOAD,
    ACT_OPD_MAC,
    ACT_OPD_LOAD,
    ACT_CLR_AEQ,
    ACT_SET_AEQ,
    ACT_SET_PEND,
    ACT_SEL_PEND,
    ACT_START,
    ACT_ACC_RES,
    ACT_RESET_ALL,
    ACT_EMIT_ACC,
    ACT_EMIT_OPD,
    ACT_EMIT_ZERO
  } act_t;

  // jump conditions
  typedef enum logic [3:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NOT_FIRST,
    CND_OPSEEN,
    CND_NOT_SECOND,
    CND_NOT_BOTH,
    CND_NO_PENDING,
    CND_DIVZERO,
    CND_BUSY,
    CND_EMIT_ERR,
    CND_FINISH
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cnd;
    upc_t  target;
  } ucode_t;

  // start request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic start;
    key_t kind;
  } alu_ctl_t;

  // program addresses
  localparam upc_t U_DIG_AEQ   = 5'd0;
  localparam upc_t U_DIG_FIRST = 5'd1;
  localparam upc_t U_DIG_SEEN  = 5'd2;
  localparam upc_t U_ACC_MAC   = 5'd3;
  localparam upc_t U_ACC_LOAD  = 5'd4;
  localparam upc_t U_OPD_SEL   = 5'd5;
  localparam upc_t U_OPD_MAC   = 5'd6;
  localparam upc_t U_OPD_LOAD  = 5'd7;
  localparam upc_t U_EMIT_OPD  = 5'd8;
  localparam upc_t U_OPR       = 5'd9;
  localparam upc_t U_OPR_BOTH  = 5'd10;
  localparam upc_t U_OPR_SEL   = 5'd11;
  localparam upc_t U_CALC      = 5'd12;
  localparam upc_t U_START     = 5'd13;
  localparam upc_t U_WAIT      = 5'd14;
  localparam upc_t U_WRITE     = 5'd15;
  localparam upc_t U_EMIT_ACC  = 5'd16;
  localparam upc_t U_FIRST_OP  = 5'd17;
  localparam upc_t U_FIRST_GO  = 5'd18;
  localparam upc_t U_EMIT_ZERO = 5'd19;
  localparam upc_t U_FINISH    = 5'd20;
  localparam upc_t U_EMIT_ERR  = 5'd21;
  localparam upc_t U_EQ        = 5'd22;
  localparam upc_t U_EQ_SEL    = 5'd23;
  localparam upc_t U_CLEAR     = 5'd24;
  localparam upc_t U_LAST      = U_CLEAR;

  // first step for each key
  function automatic upc_t entry_of(key_t k);
    upc_t e;
    unique case (k) inside
      KEY_DIGIT:                             e = U_DIG_AEQ;
      KEY_PLUS, KEY_MINUS, KEY_MUL, KEY_DIV: e = U_OPR;
      KEY_EQUALS:                            e = U_EQ;
      KEY_CLEAR:                             e = U_CLEAR;
      default:                               e = U_FINISH;
    endcase
    return e;
  endfunction

  // control store; the last two conditions are terminal markers
  function automatic ucode_t ucode(upc_t pc);
    ucode_t uc;
    case (pc)
      U_DIG_AEQ:   uc = '{act: ACT_AEQ_DROP,  cnd: CND_NEVER,      target: U_DIG_AEQ};
      U_DIG_FIRST: uc = '{act: ACT_NONE,      cnd: CND_NOT_FIRST,  target: U_ACC_LOAD};
      U_DIG_SEEN:  uc = '{act: ACT_NONE,      cnd: CND_OPSEEN,     target: U_OPD_SEL};
      U_ACC_MAC:   uc = '{act: ACT_ACC_MAC,   cnd: CND_ALWAYS,     target: U_EMIT_ACC};
      U_ACC_LOAD:  uc = '{act: ACT_ACC_LOAD,  cnd: CND_ALWAYS,     target: U_EMIT_ACC};
      U_OPD_SEL:   uc = '{act: ACT_NONE,      cnd: CND_NOT_SECOND, target: U_OPD_LOAD};
      U_OPD_MAC:   uc = '{act: ACT_OPD_MAC,   cnd: CND_ALWAYS,     target: U_EMIT_OPD};
      U_OPD_LOAD:  uc = '{act: ACT_OPD_LOAD,  cnd: CND_NEVER,      target: U_EMIT_OPD};
      U_EMIT_OPD:  uc = '{act: ACT_EMIT_OPD,  cnd: CND_NEVER,      target: U_EMIT_OPD};
      U_OPR:       uc = '{act: ACT_CLR_AEQ,   cnd: CND_NO_PENDING, target: U_FIRST_OP};
      U_OPR_BOTH:  uc = '{act: ACT_NONE,      cnd: CND_NOT_BOTH,   target: U_FINISH};
      U_OPR_SEL:   uc = '{act: ACT_SEL_PEND,  cnd: CND_NEVER,      target: U_CALC};
      U_CALC:      uc = '{act: ACT_NONE,      cnd: CND_DIVZERO,    target: U_EMIT_ERR};
      U_START:     uc = '{act: ACT_START,     cnd: CND_NEVER,      target: U_WAIT};
      U_WAIT:      uc = '{act: ACT_NONE,      cnd: CND_BUSY,       target: U_WAIT};
      U_WRITE:     uc = '{act: ACT_ACC_RES,   cnd: CND_NEVER,      target: U_EMIT_ACC};
      U_EMIT_ACC:  uc = '{act: ACT_EMIT_ACC,  cnd: CND_NEVER,      target: U_EMIT_ACC};
      U_FIRST_OP:  uc = '{act: ACT_SET_PEND,  cnd: CND_NOT_BOTH,   target: U_EMIT_ZERO};
      U_FIRST_GO:  uc = '{act: ACT_NONE,      cnd: CND_ALWAYS,     target: U_CALC};
      U_EMIT_ZERO: uc = '{act: ACT_EMIT_ZERO, cnd: CND_NEVER,      target: U_EMIT_ZERO};
      U_FINISH:    uc = '{act: ACT_NONE,      cnd: CND_FINISH,     target: U_FINISH};
      U_EMIT_ERR:  uc = '{act: ACT_NONE,      cnd: CND_EMIT_ERR,   target: U_EMIT_ERR};
      U_EQ:        uc = '{act: ACT_SET_AEQ,   cnd: CND_NOT_BOTH,   target: U_FINISH};
      U_EQ_SEL:    uc = '{act: ACT_SEL_PEND,  cnd: CND_ALWAYS,     target: U_CALC};
      U_CLEAR:     uc = '{act: ACT_RESET_ALL, cnd: CND_ALWAYS,     target: U_EMIT_ZERO};
      default:     uc = '{act: ACT_NONE,      cnd: CND_FINISH,     target: U_FINISH};
    endcase
    return uc;
  endfunction

endpackage

// ===== sv/cks_alu.sv =====
`timescale 1ns / 1ps
module cks_alu
  import cks_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  alu_ctl_t               ctl,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output logic                   busy,
  output logic [VALUE_WIDTH-1:0] result
);

  localparam int W     = VALUE_WIDTH;
  localparam int CNT_W = $clog2(W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV
  } state_t;

  state_t           state;
  key_t             kind_r;
  logic             neg;
  logic [W-1:0]     qa;     // multiplicand, or dividend shifting into quotient
  logic [W-1:0]     qb;     // multiplier, or divisor magnitude
  logic [W-1:0]     r;      // product, remainder, or add/sub result
  logic [CNT_W-1:0] cnt;

  // restoring divide step
  logic [W-1:0] rem_shift;
  logic [W:0]   diff;

  assign rem_shift = {r[W-2:0], qa[W-1]};
  assign diff      = {1'b0, rem_shift} - {1'b0, qb};

  // sign fix of the quotient on the way out
  assign busy   = (state != S_IDLE);
  assign result = (kind_r == KEY_DIV) ? (neg ? ('0 - qa) : qa) : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      kind_r <= PEND_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            kind_r <= ctl.kind;
            case (ctl.kind)
              KEY_PLUS:  r <= a + b;
              KEY_MINUS: r <= a - b;
              KEY_MUL: begin
                qa    <= a;
                qb    <= b;
                r     <= '0;
                cnt   <= CNT_W'(W - 1);
                state <= S_MUL;
              end
              KEY_DIV: begin
                neg   <= a[W-1] ^ b[W-1];
                qa    <= a[W-1] ? ('0 - a) : a;
                qb    <= b[W-1] ? ('0 - b) : b;
                r     <= '0;
                cnt   <= CNT_W'(W - 1);
                state <= S_DIV;
              end
              default:   r <= a;
            endcase
          end
        end
        // shift-add multiply, one multiplier bit a cycle
        S_MUL: begin
          if (qb[0]) begin
            r <= r + qa;
          end
          qa  <= qa << 1;
          qb  <= qb >> 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_IDLE;
          end
        end
        // one quotient bit a cycle
        S_DIV: begin
          if (!diff[W]) begin
            r  <= diff[W-1:0];
            qa <= {qa[W-2:0], 1'b1};
          end else begin
            r  <= rem_shift;
            qa <= {qa[W-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/calculator_key_sequencer.sv =====
// channel   direction  tdata                       tuser
// s_axis    in         [3:0] digit, [7:4] zero      [2:0] op
// m_axis    out        [31:0] display_value         [0] error
//
// multiply and divide run in a one-bit-a-cycle unit
// rst is synchronous and clears all calculator state at once
// results sit in an output register; a result step waits there only while
// the previous result has not been taken
`timescale 1ns / 1ps
`include "calculator_key_sequencer_defines.svh"
module calculator_key_sequencer
  import cks_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] digit, [7:4] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] display_value
  output logic        m_axis_tuser    // [0] error
);

  localparam int W = VALUE_WIDTH;

  // sequencer state
  logic   active;
  upc_t   pc;
  key_t   key_r;
  logic [3:0] dig_r;

  // calculator state
  logic [W-1:0] acc;
  logic [W-1:0] opd;
  logic         first;
  logic         second;
  key_t         pend;
  logic         opseen;
  logic         aeq;
  key_t         kind;

  // datapath helpers
  ucode_t        uw;
  logic          cond_hit;
  logic          is_emit;
  logic          stall;
  logic          emit_now;
  upc_t          pc_next;
  logic [W-1:0]  acc_mac;
  logic [W-1:0]  opd_mac;
  logic signed [W-1:0] acc_s;
  logic signed [W-1:0] opd_s;
  alu_ctl_t      alu_ctl;
  logic          alu_busy;
  logic [W-1:0]  alu_result;

  assign s_axis_tready = !active;

  // current control word
  assign uw = ucode(pc);

  // value*10 + digit
  assign acc_mac = (acc << 3) + (acc << 1) + W'(dig_r);
  assign opd_mac = (opd << 3) + (opd << 1) + W'(dig_r);
  assign acc_s   = acc;
  assign opd_s   = opd;

  // jump condition
  always_comb begin
    unique case (uw.cnd)
      CND_NEVER:      cond_hit = 1'b0;
      CND_ALWAYS:     cond_hit = 1'b1;
      CND_NOT_FIRST:  cond_hit = !first;
      CND_OPSEEN:     cond_hit = opseen;
      CND_NOT_SECOND: cond_hit = !second;
      CND_NOT_BOTH:   cond_hit = !(first && second);
      CND_NO_PENDING: cond_hit = (pend == PEND_NONE);
      CND_DIVZERO:    cond_hit = (kind == KEY_DIV) && (opd == '0);
      CND_BUSY:       cond_hit = alu_busy;
      default:        cond_hit = 1'b0;
    endcase
  end

  assign pc_next = cond_hit ? uw.target : pc + 1'b1;

  // result steps wait for a free output register
  always_comb begin
    unique case (uw.act) inside
      ACT_EMIT_ACC, ACT_EMIT_OPD, ACT_EMIT_ZERO: is_emit = 1'b1;
      default:                                   is_emit = (uw.cnd == CND_EMIT_ERR);
    endcase
  end

  assign stall    = is_emit && m_axis_tvalid && !m_axis_tready;
  assign emit_now = active && is_emit && !stall;

  assign alu_ctl.start = active && (uw.act == ACT_START);
  assign alu_ctl.kind  = kind;

  cks_alu #(
    .VALUE_WIDTH(W)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .ctl   (alu_ctl),
    .a     (acc),
    .b     (opd),
    .busy  (alu_busy),
    .result(alu_result)
  );

  // sequencer, calculator state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      pc            <= U_FINISH;
      key_r         <= PEND_NONE;
      acc           <= '0;
      opd           <= '0;
      first         <= 1'b0;
      second        <= 1'b0;
      pend          <= PEND_NONE;
      opseen        <= 1'b0;
      aeq           <= 1'b0;
      kind          <= PEND_NONE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && !emit_now) begin
        m_axis_tvalid <= 1'b0;
      end
      if (!active) begin
        if (s_axis_tvalid) begin
          active <= 1'b1;
          key_r  <= key_t'(s_axis_tuser);
          dig_r  <= s_axis_tdata[3:0];
          pc     <= entry_of(key_t'(s_axis_tuser));
        end
      end else if (!stall) begin
        pc <= pc_next;
        unique case (uw.act)
          ACT_NONE: ;
          ACT_AEQ_DROP: begin
            if (aeq) begin
              first <= 1'b0;
              aeq   <= 1'b0;
            end
          end
          ACT_ACC_MAC:  acc <= acc_mac;
          ACT_ACC_LOAD: begin
            acc   <= W'(dig_r);
            first <= 1'b1;
          end
          ACT_OPD_MAC:  opd <= opd_mac;
          ACT_OPD_LOAD: begin
            opd    <= W'(dig_r);
            second <= 1'b1;
          end
          ACT_CLR_AEQ:  aeq <= 1'b0;
          ACT_SET_AEQ:  aeq <= 1'b1;
          ACT_SET_PEND: begin
            pend   <= key_r;
            kind   <= key_r;
            opseen <= 1'b1;
          end
          ACT_SEL_PEND: kind <= pend;
          ACT_START: ;
          ACT_ACC_RES: begin
            acc    <= alu_result;
            second <= 1'b0;
            pend   <= (key_r == KEY_EQUALS) ? PEND_NONE : key_r;
          end
          ACT_RESET_ALL: begin
            acc    <= '0;
            opd    <= '0;
            first  <= 1'b0;
            second <= 1'b0;
            pend   <= PEND_NONE;
            opseen <= 1'b0;
            aeq    <= 1'b0;
          end
          ACT_EMIT_ACC: begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= 32'(acc_s);
            m_axis_tuser  <= 1'b0;
            active        <= 1'b0;
          end
          ACT_EMIT_OPD: begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= 32'(opd_s);
            m_axis_tuser  <= 1'b0;
            active        <= 1'b0;
          end
          ACT_EMIT_ZERO: begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= '0;
            m_axis_tuser  <= 1'b0;
            active        <= 1'b0;
          end
          default: ;
        endcase
        // terminal steps carried in the condition field
        if (uw.cnd == CND_EMIT_ERR) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= '0;
          m_axis_tuser  <= 1'b1;
          active        <= 1'b0;
        end
        if (uw.cnd == CND_FINISH) begin
          active <= 1'b0;
        end
      end
    end
  end

  // checks
  `CKS_ASSERT_NEXT(a_accept_starts, s_axis_tvalid && s_axis_tready, active)
  `CKS_ASSERT_IMPL(a_alu_in_program, alu_busy, active)
  `CKS_ASSERT_IMPL(a_pc_in_range, active, pc <= U_LAST)
  `CKS_ASSERT_IMPL(a_second_needs_first, !active, !(second && !first))

endmodule
